>>> rtl/cots_pkg.sv
// Shared types and constants of the clock offset time sync block.
package cots_pkg;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_SYNC     = 2'd0;
   localparam logic [1:0] CMD_ESTIMATE = 2'd1;
   localparam logic [1:0] CMD_STATUS   = 2'd2;

   // Configuration register map (word index taken from paddr[2]).
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam logic        CSR_WINDOW_IDX = 1'b0;
   localparam logic [31:0] WINDOW_RESET   = 32'd60000;

   // Quality score constants.
   localparam logic [7:0] FIRST_QUALITY = 8'd128;
   localparam logic [7:0] QUALITY_CAP   = 8'd250;
   localparam logic [7:0] GAP_PENALTY   = 8'd10;
   localparam logic [7:0] QUALITY_STEP  = 8'd5;

   // The offset and the estimate both fit in 50 bits two's complement.
   localparam int unsigned AVG_W = 50;
   localparam int unsigned SUM_W = AVG_W + 2;

   // Divider by milliseconds per second: three 17-bit quotient digits, each
   // found by multiplying the partial value by a scaled reciprocal of 1000.
   // The partial value stays below 2^27, where the reciprocal is exact.
   localparam int unsigned MS_PER_S    = 1000;
   localparam int unsigned DIGIT_W     = 17;
   localparam int unsigned NUM_W       = 51;
   localparam int unsigned DIV_DIGITS  = NUM_W / DIGIT_W;
   localparam int unsigned STEP_W      = 2;
   localparam int unsigned REM_W       = 10;
   localparam int unsigned PART_W      = REM_W + DIGIT_W;
   localparam int unsigned RECIP_W     = 28;
   localparam int unsigned RECIP_SHIFT = 37;
   localparam int unsigned PROD_W      = PART_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 28'd137438954;

   typedef enum logic [1:0] {
      OP_SYNC,
      OP_ESTIMATE,
      OP_STATUS,
      OP_NONE
   } op_kind_type;

   typedef struct packed {
      op_kind_type  kind;
      logic [31:0]  now_ms;
      logic [47:0]  watch_time_ms;
      logic [31:0]  sync_seq;
      logic [31:0]  max_age_ms;
   } item_type;

   typedef struct packed {
      logic         update_accepted;
      logic [31:0]  unix_seconds;
      logic         is_synced;
      logic [7:0]   sync_quality;
   } result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SYNC,
      BK_DIV
   } back_state_type;

endpackage

>>> rtl/cots_front.sv
// Front end: request acceptance, command classification and a two-entry queue.
module cots_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [31:0]        req_now_ms,
   input  logic [47:0]        req_watch_time_ms,
   input  logic [31:0]        req_sync_seq,
   input  logic [31:0]        req_max_age_ms,
   output cots_pkg::item_type head_item,
   output logic               head_valid,
   input  logic               pop
);
   import cots_pkg::*;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   item_type    queue_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        push;
   op_kind_type kind;
   item_type    new_item;

   always_comb begin
      unique case (req_command)
         CMD_SYNC:     kind = OP_SYNC;
         CMD_ESTIMATE: kind = OP_ESTIMATE;
         CMD_STATUS:   kind = OP_STATUS;
         default:      kind = OP_NONE;
      endcase
   end

   assign new_item = '{kind:          kind,
                       now_ms:        req_now_ms,
                       watch_time_ms: req_watch_time_ms,
                       sync_seq:      req_sync_seq,
                       max_age_ms:    req_max_age_ms};

   assign req_stall  = (count_ff == QUEUE_DEPTH);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/cots_div.sv
// Three-step divider by 1000 using reciprocal multiplication, saturating to 32 bits.
module cots_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cots_pkg::NUM_W-1:0] dividend,
   output logic                       done,
   output logic [31:0]                quotient
);
   import cots_pkg::*;

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [PART_W-1:0]  part;
   logic [PROD_W-1:0]  prod;
   logic [PART_W-1:0]  rem_sel;
   logic [DIGIT_W-1:0] digit;

   // One quotient digit per cycle: the partial value times the scaled
   // reciprocal of 1000 gives the digit, and the remainder carries on.
   always_comb begin
      part    = {rem_ff, num_ff[NUM_W-1 -: DIGIT_W]};
      prod    = PROD_W'(part) * PROD_W'(RECIP);
      digit   = prod[RECIP_SHIFT +: DIGIT_W];
      rem_sel = part - PART_W'(digit) * PART_W'(MS_PER_S);
   end

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         quo_in  = {quo_ff[NUM_W-DIGIT_W-1:0], digit};
         rem_in  = rem_sel[REM_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[NUM_W-1:32]) ? '1 : quo_ff[31:0];

endmodule

>>> rtl/cots_back.sv
// Back end: sync state, command execution and the result output register.
module cots_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cots_pkg::item_type   head_item,
   input  logic                 head_valid,
   output logic                 pop,
   input  logic [31:0]          window_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cots_pkg::result_type rsp_result
);
   import cots_pkg::*;

   back_state_type state_ff, state_in;

   // Tracker state.
   logic             sync_valid_ff, sync_valid_in;
   logic [31:0]      last_seq_ff, last_seq_in;
   logic [AVG_W-1:0] avg_ff, avg_in;
   logic [31:0]      last_update_ff, last_update_in;
   logic [7:0]       quality_ff, quality_in;

   // Working registers of the request in flight.
   logic [31:0]      w_now_ff, w_now_in;
   logic [31:0]      w_seq_ff, w_seq_in;
   logic             accept_ff, accept_in;
   logic             first_ff, first_in;
   logic             gap_ff, gap_in;
   logic [AVG_W-1:0] offset_ff, offset_in;
   logic [SUM_W-1:0] sum3_ff, sum3_in;
   logic             est_ok_ff, est_ok_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff, rsp_res_in;

   logic             out_free;
   logic [31:0]      age;
   logic [AVG_W-1:0] offset_c;
   logic [SUM_W-1:0] sum3_c;
   logic [AVG_W-1:0] est_c;
   logic             est_ok_c;
   logic             accept_c;
   logic             gap_c;
   logic [SUM_W-1:0] total;
   logic [SUM_W-1:0] total_q;
   logic [7:0]       q_gap;
   logic [7:0]       q_new;
   logic             div_start;
   logic             div_done;
   logic [31:0]      div_quotient;
   logic [NUM_W-1:0] div_dividend;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // First stage, straight from the queue head.
   always_comb begin
      age      = head_item.now_ms - last_update_ff;
      offset_c = {2'b00, head_item.watch_time_ms} - {{(AVG_W-32){1'b0}}, head_item.now_ms};
      sum3_c   = {{2{avg_ff[AVG_W-1]}}, avg_ff} + {avg_ff[AVG_W-1], avg_ff, 1'b0};
      est_c    = {{(AVG_W-32){1'b0}}, head_item.now_ms} + avg_ff;
      est_ok_c = sync_valid_ff && (age <= window_ms) && !est_c[AVG_W-1] && (est_c != '0);
      accept_c = !sync_valid_ff || (head_item.sync_seq > last_seq_ff);
      gap_c    = (head_item.sync_seq != last_seq_ff + 32'd1);
      div_dividend = {{(NUM_W-AVG_W+1){1'b0}}, est_c[AVG_W-2:0]};
   end

   // Second stage of a sync: average update with truncation toward zero.
   always_comb begin
      total   = sum3_ff + {{2{offset_ff[AVG_W-1]}}, offset_ff};
      total_q = {{2{total[SUM_W-1]}}, total[SUM_W-1:2]}
              + {{(SUM_W-1){1'b0}}, total[SUM_W-1] && (total[1:0] != 2'b00)};
      q_gap   = (gap_ff && quality_ff > GAP_PENALTY) ? quality_ff - GAP_PENALTY : quality_ff;
      q_new   = (q_gap < QUALITY_CAP) ? q_gap + QUALITY_STEP : q_gap;
   end

   always_comb begin
      state_in       = state_ff;
      sync_valid_in  = sync_valid_ff;
      last_seq_in    = last_seq_ff;
      avg_in         = avg_ff;
      last_update_in = last_update_ff;
      quality_in     = quality_ff;
      w_now_in       = w_now_ff;
      w_seq_in       = w_seq_ff;
      accept_in      = accept_ff;
      first_in       = first_ff;
      gap_in         = gap_ff;
      offset_in      = offset_ff;
      sum3_in        = sum3_ff;
      est_ok_in      = est_ok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_res_in     = rsp_res_ff;
      pop            = 1'b0;
      div_start      = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               unique case (head_item.kind)
                  OP_SYNC: begin
                     pop       = 1'b1;
                     w_now_in  = head_item.now_ms;
                     w_seq_in  = head_item.sync_seq;
                     accept_in = accept_c;
                     first_in  = !sync_valid_ff;
                     gap_in    = gap_c;
                     offset_in = offset_c;
                     sum3_in   = sum3_c;
                     state_in  = BK_SYNC;
                  end
                  OP_ESTIMATE: begin
                     pop       = 1'b1;
                     div_start = 1'b1;
                     est_ok_in = est_ok_c;
                     state_in  = BK_DIV;
                  end
                  OP_STATUS, OP_NONE: begin
                     if (out_free) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_res_in   = '{update_accepted: 1'b0,
                                         unix_seconds:    32'd0,
                                         is_synced:       (head_item.kind == OP_STATUS)
                                                          && sync_valid_ff
                                                          && (age <= head_item.max_age_ms),
                                         sync_quality:    quality_ff};
                     end
                  end
               endcase
            end
         end
         BK_SYNC: begin
            if (out_free) begin
               if (accept_ff) begin
                  sync_valid_in  = 1'b1;
                  last_seq_in    = w_seq_ff;
                  last_update_in = w_now_ff;
                  avg_in         = first_ff ? offset_ff : total_q[AVG_W-1:0];
                  quality_in     = first_ff ? FIRST_QUALITY : q_new;
               end
               rsp_valid_in = 1'b1;
               rsp_res_in   = '{update_accepted: accept_ff,
                                unix_seconds:    32'd0,
                                is_synced:       1'b0,
                                sync_quality:    accept_ff ? quality_in : quality_ff};
               state_in     = BK_IDLE;
            end
         end
         BK_DIV: begin
            if (div_done && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = '{update_accepted: 1'b0,
                                unix_seconds:    est_ok_ff ? div_quotient : 32'd0,
                                is_synced:       1'b0,
                                sync_quality:    quality_ff};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         sync_valid_ff  <= 1'b0;
         last_seq_ff    <= '0;
         avg_ff         <= '0;
         last_update_ff <= '0;
         quality_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sync_valid_ff  <= sync_valid_in;
         last_seq_ff    <= last_seq_in;
         avg_ff         <= avg_in;
         last_update_ff <= last_update_in;
         quality_ff     <= quality_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_now_ff   <= w_now_in;
      w_seq_ff   <= w_seq_in;
      accept_ff  <= accept_in;
      first_ff   <= first_in;
      gap_ff     <= gap_in;
      offset_ff  <= offset_in;
      sum3_ff    <= sum3_in;
      est_ok_ff  <= est_ok_in;
      rsp_res_ff <= rsp_res_in;
   end

   cots_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_res_ff;

endmodule

>>> rtl/clock_offset_time_sync_top.sv
// Top level of the clock offset time sync block: CSR, front end and back end.
//
//   Channel   Direction  Handshake              Payload
//   req_*     in         req_valid / req_stall  command, now_ms, watch_time_ms, sync_seq,
//                                               max_age_ms
//   rsp_*     out        rsp_valid / rsp_stall  update_accepted, unix_seconds, is_synced,
//                                               sync_quality
//   APB       in/out     psel, penable, pready  paddr, pwdata, prdata (estimate_window_ms)
//
// Every request gives exactly one response, in request order.
// A status query or an unknown command is answered from the back end's idle state,
// a sync message passes through a second state, and an estimate query waits for the
// divider by 1000 that finds one 17-bit quotient digit per cycle over 3 digits.
// A two-entry queue lets the front end take new requests while the back end
// works and while a finished response waits in the output register.
// Reset is synchronous and active high; it clears the queue, the tracker state
// and the output valid, and loads estimate_window_ms with 60000.
// req_stall rises only when the queue is full; a stalled response holds its payload.
module clock_offset_time_sync_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [31:0]                   req_now_ms,
   input  logic [47:0]                   req_watch_time_ms,
   input  logic [31:0]                   req_sync_seq,
   input  logic [31:0]                   req_max_age_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_update_accepted,
   output logic [31:0]                   rsp_unix_seconds,
   output logic                          rsp_is_synced,
   output logic [7:0]                    rsp_sync_quality,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cots_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import cots_pkg::*;

   logic [31:0] window_ff, window_in;
   logic        csr_write;
   item_type    head_item;
   logic        head_valid;
   logic        pop;
   result_type  rsp_result;

   // The configuration port has no wait states. Only one register exists, so
   // the word index is a single address bit; the other word index reads as zero.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      window_in = window_ff;
      if (csr_write && (paddr[2] == CSR_WINDOW_IDX)) begin
         window_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign prdata = (paddr[2] == CSR_WINDOW_IDX) ? window_ff : 32'd0;

   // The front end classifies each request and queues it.
   cots_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_now_ms        (req_now_ms),
      .req_watch_time_ms (req_watch_time_ms),
      .req_sync_seq      (req_sync_seq),
      .req_max_age_ms    (req_max_age_ms),
      .head_item         (head_item),
      .head_valid        (head_valid),
      .pop               (pop)
   );

   // The back end owns the tracker state and executes requests in order, so a
   // query always sees every earlier sync already applied.
   cots_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .pop        (pop),
      .window_ms  (window_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_update_accepted = rsp_result.update_accepted;
   assign rsp_unix_seconds    = rsp_result.unix_seconds;
   assign rsp_is_synced       = rsp_result.is_synced;
   assign rsp_sync_quality    = rsp_result.sync_quality;

endmodule

>>> rtl/cots_checker.sv
// Port-level checker of the clock offset time sync block and its bind.
module cots_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_update_accepted,
   input logic [31:0] rsp_unix_seconds,
   input logic        rsp_is_synced,
   input logic [7:0]  rsp_sync_quality
);

   // The response register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_unix_seconds)
                                 && $stable(rsp_sync_quality))
      else $error("stalled response changed");

   // A response answers one kind of request only.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_update_accepted, rsp_unix_seconds != 32'd0,
                                rsp_is_synced}) <= 1)
      else $error("response mixes fields of different commands");

   // An accepted sync never reports a quality of zero.
   a_quality_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_accepted |-> rsp_sync_quality != 8'd0)
      else $error("accepted sync with zero quality");

   // Quality only rises by 5 below 250, so it stays at most 254.
   a_quality_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sync_quality <= 8'd254)
      else $error("quality above its ceiling");

endmodule

bind clock_offset_time_sync_top cots_checker u_cots_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_update_accepted (rsp_update_accepted),
   .rsp_unix_seconds    (rsp_unix_seconds),
   .rsp_is_synced       (rsp_is_synced),
   .rsp_sync_quality    (rsp_sync_quality)
);

>>> sim/clock_offset_time_sync_top_tb.sv
// Self-checking testbench for the clock offset time sync block.
module clock_offset_time_sync_top_tb;
   import cots_pkg::*;

   // Run control. The cycle limit is far above the slowest correct run, which is
   // about 700 requests plus the drains between phases.
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned HOLD_CYCLES   = 60;
   localparam int unsigned PHASE_ITEMS   = 130;

   // Tracker constants, kept separate from the package so that the prediction
   // does not share a mistake with the design.
   localparam logic [7:0]  SCORE_START     = 8'd128;
   localparam logic [7:0]  SCORE_CEILING   = 8'd250;
   localparam logic [7:0]  GAP_DROP        = 8'd10;
   localparam logic [7:0]  SCORE_RAISE     = 8'd5;
   localparam longint      MS_IN_SECOND    = 1000;
   localparam logic [31:0] WINDOW_AT_RESET = 32'd60000;
   localparam logic [47:0] WATCH_MAX       = '1;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = {CSR_WINDOW_IDX, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_command = '0;
   logic [31:0]           req_now_ms = '0;
   logic [47:0]           req_watch_time_ms = '0;
   logic [31:0]           req_sync_seq = '0;
   logic [31:0]           req_max_age_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_update_accepted;
   logic [31:0]           rsp_unix_seconds;
   logic                  rsp_is_synced;
   logic [7:0]            rsp_sync_quality;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Our own copy of the tracker state and of the window register.
   logic        trk_valid = 1'b0;
   logic [31:0] trk_last_seq = '0;
   logic [31:0] trk_last_update = '0;
   longint      trk_avg = 0;
   logic [7:0]  trk_quality = '0;
   logic [31:0] window_ms = WINDOW_AT_RESET;

   // Responses still owed by the block, oldest first.
   result_type  expected_q[$];
   result_type  resp_want;
   int unsigned error_count = 0;

   // Shared between the stimulus and the response stall process.
   bit          idle_on = 1'b0;
   bit          hold_output = 1'b0;

   // Random traffic models a local counter and a remote clock at a jumping offset.
   logic [31:0] local_ms = 32'h7FFF_F000;
   longint      remote_offset = 64'sd1_700_000_000_000;

   always #5 clock = ~clock;

   clock_offset_time_sync_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_now_ms          (req_now_ms),
      .req_watch_time_ms   (req_watch_time_ms),
      .req_sync_seq        (req_sync_seq),
      .req_max_age_ms      (req_max_age_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_update_accepted (rsp_update_accepted),
      .rsp_unix_seconds    (rsp_unix_seconds),
      .rsp_is_synced       (rsp_is_synced),
      .rsp_sync_quality    (rsp_sync_quality),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // Applies one accepted request to the tracker copy and returns the response
   // it must produce. Every request gives exactly one response.
   function automatic result_type predict_response(input item_type it);
      result_type r;
      longint     offset;
      longint     est;
      longint     secs;
      logic [31:0] age;
      r = '0;
      age = it.now_ms - trk_last_update;
      case (it.kind)
         OP_SYNC: begin
            // A sync only counts when it is newer than the last accepted one,
            // or when nothing has been accepted yet.
            if (!trk_valid || it.sync_seq > trk_last_seq) begin
               offset = longint'({16'd0, it.watch_time_ms}) - longint'({32'd0, it.now_ms});
               if (!trk_valid) begin
                  trk_avg = offset;
                  trk_quality = SCORE_START;
               end else begin
                  if (it.sync_seq != trk_last_seq + 32'd1 && trk_quality > GAP_DROP)
                     trk_quality = trk_quality - GAP_DROP;
                  // Signed division truncates toward zero, as the design must.
                  trk_avg = (trk_avg * 3 + offset) / 4;
                  if (trk_quality < SCORE_CEILING)
                     trk_quality = trk_quality + SCORE_RAISE;
               end
               trk_last_update = it.now_ms;
               trk_last_seq = it.sync_seq;
               trk_valid = 1'b1;
               r.update_accepted = 1'b1;
            end
         end
         OP_ESTIMATE: begin
            if (trk_valid && age <= window_ms) begin
               est = longint'({32'd0, it.now_ms}) + trk_avg;
               if (est > 0) begin
                  secs = est / MS_IN_SECOND;
                  // Quotients beyond 32 bits saturate.
                  r.unix_seconds = (secs[63:32] != 0) ? 32'hFFFF_FFFF : secs[31:0];
               end
            end
         end
         OP_STATUS: begin
            r.is_synced = trk_valid && (age <= it.max_age_ms);
         end
         default: ;
      endcase
      r.sync_quality = trk_quality;
      return r;
   endfunction

   function automatic item_type make_item(input op_kind_type kind, input logic [31:0] now,
                                          input logic [47:0] watch, input logic [31:0] seq,
                                          input logic [31:0] max_age);
      item_type it;
      it.kind = kind;
      it.now_ms = now;
      it.watch_time_ms = watch;
      it.sync_seq = seq;
      it.max_age_ms = max_age;
      return it;
   endfunction

   // Draws one random request. Most are well-formed: syncs that follow the
   // sequence and the remote clock, and queries close to the last sync. The
   // rest are unknown commands and random noise, whose syncs are kept stale.
   function automatic item_type random_item();
      item_type    it;
      int unsigned pick;
      longint      watch_val;
      logic [31:0] age;
      it.kind = op_kind_type'($urandom_range(0, 3));
      it.now_ms = $urandom;
      it.watch_time_ms[47:32] = 16'($urandom);
      it.watch_time_ms[31:0] = $urandom;
      it.sync_seq = $urandom;
      it.max_age_ms = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         // The remote clock jumps: real wall time, anywhere in 48 bits, or
         // slightly behind the local counter so estimates go non-positive.
         case ($urandom_range(0, 2))
            0: remote_offset = 64'sd1_700_000_000_000 + longint'($urandom_range(0, 100000000));
            1: remote_offset = longint'({16'd0, 16'($urandom), $urandom});
            default: remote_offset = -longint'($urandom_range(0, 1000000000));
         endcase
      end
      if (pick < 40) begin
         it.kind = OP_SYNC;
         local_ms += $urandom_range(0, 4000);
         it.now_ms = local_ms;
         watch_val = longint'({32'd0, local_ms}) + remote_offset
                     + longint'($urandom_range(0, 200)) - 100;
         if (watch_val < 0)
            watch_val = 0;
         else if (watch_val > longint'({16'd0, WATCH_MAX}))
            watch_val = longint'({16'd0, WATCH_MAX});
         it.watch_time_ms = watch_val[47:0];
         case ($urandom_range(0, 9))
            0: it.sync_seq = trk_last_seq + $urandom_range(2, 5000);
            1: it.sync_seq = $urandom_range(0, trk_last_seq);
            default: it.sync_seq = trk_last_seq + 32'd1;
         endcase
      end else if (pick < 65) begin
         it.kind = OP_ESTIMATE;
         if ($urandom_range(0, 3) == 0) begin
            // Just inside, on, or just past the edge of the window.
            it.now_ms = trk_last_update + window_ms - 1 + $urandom_range(0, 2);
         end else begin
            local_ms += $urandom_range(0, 2000);
            it.now_ms = local_ms;
         end
      end else if (pick < 85) begin
         it.kind = OP_STATUS;
         local_ms += $urandom_range(0, 2000);
         it.now_ms = local_ms;
         age = local_ms - trk_last_update;
         case ($urandom_range(0, 2))
            0: it.max_age_ms = age - 1 + $urandom_range(0, 2);
            1: it.max_age_ms = $urandom_range(0, 10000);
            default: ;
         endcase
      end else if (pick < 90) begin
         it.kind = OP_NONE;
      end else if (it.kind == OP_SYNC) begin
         // Noise syncs are stale so that they never lock the sequence near its top.
         it.sync_seq = $urandom_range(0, trk_last_seq);
      end
      return it;
   endfunction

   // Offers one request, with an optional short idle gap first, and records
   // its expected response once the block has taken it.
   task automatic send_request(input item_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.kind;
      req_now_ms <= it.now_ms;
      req_watch_time_ms <= it.watch_time_ms;
      req_sync_seq <= it.sync_seq;
      req_max_age_ms <= it.max_age_ms;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(predict_response(it));
   endtask

   // Stops offering and waits until every response is in and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the estimate window while the block is idle, then reads it back.
   task automatic set_window(input logic [31:0] value);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= WINDOW_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      window_ms = value;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         $error("estimate_window_ms: expected %0d, got %0d", value, prdata);
         error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Queries and an unknown command before any sync must all answer empty.
   task automatic test_before_sync();
      send_request(make_item(OP_ESTIMATE, '0, '0, '0, '0));
      send_request(make_item(OP_STATUS, '1, WATCH_MAX, '1, '1));
      send_request(make_item(OP_NONE, '1, WATCH_MAX, '1, '1));
   endtask

   // Walks the tracker through the first sync, stale and repeated sequence
   // numbers, a consecutive update, a gap, negative averages that must truncate
   // toward zero, a non-positive estimate, a saturated estimate and the status
   // comparison at both extremes of the maximum age.
   task automatic test_sync_tracking();
      send_request(make_item(OP_SYNC, '1, '0, '0, '1));
      send_request(make_item(OP_ESTIMATE, '1, WATCH_MAX, '1, '0));
      send_request(make_item(OP_ESTIMATE, '0, '0, '0, '0));
      send_request(make_item(OP_SYNC, 32'd5, 48'd7, '0, '0));
      send_request(make_item(OP_SYNC, '0, 48'd2, 32'd1, '0));
      send_request(make_item(OP_SYNC, 32'd10, WATCH_MAX, 32'd4, '0));
      send_request(make_item(OP_SYNC, 32'd11, 48'd1, 32'd3, '0));
      send_request(make_item(OP_ESTIMATE, 32'd20, '0, '0, '0));
      send_request(make_item(OP_STATUS, 32'd10, '0, '0, '0));
      send_request(make_item(OP_STATUS, 32'd11, '0, '0, '0));
      send_request(make_item(OP_STATUS, 32'd9, '0, '0, 32'hFFFF_FFFE));
      send_request(make_item(OP_STATUS, 32'd9, '0, '0, '1));
      send_request(make_item(OP_NONE, '0, '0, '0, '0));
      send_request(make_item(OP_SYNC, 32'd1000, 48'd1_700_000_001_000, 32'd5, '0));
   endtask

   // Estimates right on the edge of the window, for the narrowest, the widest
   // and the reset window.
   task automatic test_window_limits();
      set_window('0);
      send_request(make_item(OP_ESTIMATE, trk_last_update, '0, '0, '0));
      send_request(make_item(OP_ESTIMATE, trk_last_update + 32'd1, '0, '0, '0));
      set_window('1);
      send_request(make_item(OP_ESTIMATE, trk_last_update - 32'd1, '0, '0, '0));
      set_window(WINDOW_AT_RESET);
      send_request(make_item(OP_ESTIMATE, trk_last_update + WINDOW_AT_RESET, '0, '0, '0));
      send_request(make_item(OP_ESTIMATE, trk_last_update + WINDOW_AT_RESET + 32'd1,
                             '0, '0, '0));
   endtask

   // The response side holds off for a long stretch while requests keep
   // coming back to back, so the queue fills and the block stalls its input.
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_output = 1'b1;
      repeat (12) send_request(random_item());
      drain();
   endtask

   // Random traffic in phases, each with its own window. Idling comes and
   // goes in stretches and stays off for the whole last phase.
   task automatic test_random_traffic();
      logic [31:0] windows [5];
      windows[0] = WINDOW_AT_RESET;
      windows[1] = 32'hFFFF_FFFF;
      windows[2] = 32'd0;
      windows[3] = 32'd5000;
      windows[4] = $urandom_range(1000, 300000);
      for (int phase = 0; phase < 5; phase++) begin
         set_window(windows[phase]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idle_on = (phase < 4) && ((n / 40) % 2 == 0);
            send_request(random_item());
         end
      end
   endtask

   // Runs the sequence number to its top. A wrapped number is not newer, so
   // the sync that carries it is ignored.
   task automatic test_sequence_end();
      idle_on = 1'b0;
      send_request(make_item(OP_SYNC, local_ms + 32'd10, 48'd1_700_000_500_000,
                             32'hFFFF_FFFE, '0));
      send_request(make_item(OP_SYNC, local_ms + 32'd20, 48'd1_700_000_500_010, '1, '0));
      send_request(make_item(OP_SYNC, local_ms + 32'd30, 48'd1_700_000_500_020, '0, '0));
      send_request(make_item(OP_STATUS, local_ms + 32'd40, '0, '0, 32'd20));
      send_request(make_item(OP_ESTIMATE, local_ms + 32'd50, '0, '0, '0));
   endtask

   // Response checker: every response taken is compared with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("response arrived with no request outstanding");
            error_count++;
         end else begin
            resp_want = expected_q.pop_front();
            if (rsp_update_accepted !== resp_want.update_accepted) begin
               $error("update_accepted: expected %0d, got %0d",
                      resp_want.update_accepted, rsp_update_accepted);
               error_count++;
            end
            if (rsp_unix_seconds !== resp_want.unix_seconds) begin
               $error("unix_seconds: expected %0d, got %0d",
                      resp_want.unix_seconds, rsp_unix_seconds);
               error_count++;
            end
            if (rsp_is_synced !== resp_want.is_synced) begin
               $error("is_synced: expected %0d, got %0d",
                      resp_want.is_synced, rsp_is_synced);
               error_count++;
            end
            if (rsp_sync_quality !== resp_want.sync_quality) begin
               $error("sync_quality: expected %0d, got %0d",
                      resp_want.sync_quality, rsp_sync_quality);
               error_count++;
            end
         end
      end
   end

   // Response stall: short random bursts while idling is on, and one long
   // hold-off counted here when the backpressure test asks for it.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_output = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_sync();
      test_sync_tracking();
      test_window_limits();
      test_output_backpressure();
      test_random_traffic();
      test_sequence_end();
      drain();
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
